// ===== rtl/core/irpd_pkg.sv =====
// Package: frame timing constants, phase encoding and the per-tick result struct.
package irpd_pkg;

  localparam int MAX_BITS     = 64;
  localparam int NOMINAL_BITS = 32;

  localparam logic [16:0] T_BIT_MARK   = 17'd750;
  localparam logic [16:0] T_ZERO_SPACE = 17'd750;
  localparam logic [16:0] T_ONE_SPACE  = 17'd2150;
  localparam logic [16:0] T_HDR        = 17'd2850;
  localparam logic [17:0] T_MIN_LEN    = 18'd108000;

  // Shortest gap: frame length minus the nominal frame body, clamped at zero.
  localparam int NOMINAL_BODY = 2 * (750 + 750) + NOMINAL_BITS * (750 + 2150);
  localparam int MIN_GAP_INT  = (NOMINAL_BODY < 108000) ? (108000 - NOMINAL_BODY) : 0;
  localparam logic [16:0] MIN_GAP = 17'(MIN_GAP_INT);

  localparam logic [6:0] MAX_BITS_W = 7'(MAX_BITS);

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_PRE_MARK  = 8'b0000_0010,
    PH_PRE_SPACE = 8'b0000_0100,
    PH_HDR_MARK  = 8'b0000_1000,
    PH_HDR_SPACE = 8'b0001_0000,
    PH_BIT_MARK  = 8'b0010_0000,
    PH_BIT_SPACE = 8'b0100_0000,
    PH_GAP       = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } irpd_res_t;

endpackage

// ===== rtl/core/irpd_seq.sv =====
// Frame sequencer: phase, segment timer, shift register and repeat counter.
module irpd_seq import irpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic        operation,
  input  logic [63:0] payload,
  input  logic [6:0]  bit_count,
  input  logic [15:0] repeat_count,
  output irpd_res_t   res
);

  phase_t      phase_r, phase_nxt;
  logic [16:0] seg_r, seg_nxt;
  logic [17:0] elapsed_r, elapsed_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [63:0] saved_word_r, saved_word_nxt;
  logic [6:0]  bits_left_r, bits_left_nxt;
  logic [6:0]  saved_bits_r, saved_bits_nxt;
  logic [15:0] frames_left_r, frames_left_nxt;

  logic [6:0]  n_sat;
  logic [63:0] start_word;
  logic [16:0] seg_dec;
  logic [16:0] gap_raw;
  logic [16:0] gap_len;

  assign n_sat      = (bit_count > MAX_BITS_W) ? MAX_BITS_W : bit_count;
  assign start_word = (n_sat == 7'd0) ? 64'd0 : (payload << (7'd64 - n_sat));
  assign seg_dec    = (seg_r != 17'd0) ? (seg_r - 17'd1) : seg_r;
  assign gap_raw    = (elapsed_r < T_MIN_LEN) ? 17'(T_MIN_LEN - elapsed_r) : 17'd0;
  assign gap_len    = (gap_raw < MIN_GAP) ? MIN_GAP : gap_raw;

  always_comb begin
    phase_nxt       = phase_r;
    seg_nxt         = seg_r;
    elapsed_nxt     = elapsed_r;
    shift_nxt       = shift_r;
    saved_word_nxt  = saved_word_r;
    bits_left_nxt   = bits_left_r;
    saved_bits_nxt  = saved_bits_r;
    frames_left_nxt = frames_left_r;
    res             = '0;

    if (operation) begin
      saved_bits_nxt  = n_sat;
      saved_word_nxt  = start_word;
      frames_left_nxt = repeat_count;
      shift_nxt       = start_word;
      bits_left_nxt   = n_sat;
      phase_nxt       = PH_PRE_MARK;
      seg_nxt         = T_BIT_MARK;
      elapsed_nxt     = 18'(T_BIT_MARK);
      res.busy        = 1'b1;
    end else if (phase_r != PH_IDLE) begin
      res.busy  = 1'b1;
      res.level = (phase_r == PH_PRE_MARK) || (phase_r == PH_HDR_MARK) ||
                  (phase_r == PH_BIT_MARK);
      seg_nxt   = seg_dec;
      if (seg_dec == 17'd0) begin
        // a zero gap, or the gap running out, both close the frame
        logic close_frame;
        close_frame = 1'b0;
        unique case (phase_r)
          PH_PRE_MARK: begin
            phase_nxt   = PH_PRE_SPACE;
            seg_nxt     = T_ZERO_SPACE;
            elapsed_nxt = elapsed_r + 18'(T_ZERO_SPACE);
          end
          PH_PRE_SPACE: begin
            phase_nxt   = PH_HDR_MARK;
            seg_nxt     = T_HDR;
            elapsed_nxt = elapsed_r + 18'(T_HDR);
          end
          PH_HDR_MARK: begin
            phase_nxt   = PH_HDR_SPACE;
            seg_nxt     = T_HDR;
            elapsed_nxt = elapsed_r + 18'(T_HDR);
          end
          PH_HDR_SPACE, PH_BIT_SPACE: begin
            phase_nxt   = PH_BIT_MARK;
            seg_nxt     = T_BIT_MARK;
            elapsed_nxt = elapsed_r + 18'(T_BIT_MARK);
          end
          PH_BIT_MARK: begin
            if (bits_left_r != 7'd0) begin
              shift_nxt     = {shift_r[62:0], 1'b0};
              bits_left_nxt = bits_left_r - 7'd1;
              phase_nxt     = PH_BIT_SPACE;
              seg_nxt       = shift_r[63] ? T_ONE_SPACE : T_ZERO_SPACE;
              elapsed_nxt   = elapsed_r + 18'(shift_r[63] ? T_ONE_SPACE : T_ZERO_SPACE);
            end else if (gap_len == 17'd0) begin
              close_frame = 1'b1;
            end else begin
              phase_nxt = PH_GAP;
              seg_nxt   = gap_len;
            end
          end
          default: close_frame = 1'b1;
        endcase
        if (close_frame) begin
          if (frames_left_r != 16'd0) begin
            frames_left_nxt = frames_left_r - 16'd1;
            shift_nxt       = saved_word_r;
            bits_left_nxt   = saved_bits_r;
            phase_nxt       = PH_PRE_MARK;
            seg_nxt         = T_BIT_MARK;
            elapsed_nxt     = 18'(T_BIT_MARK);
          end else begin
            phase_nxt = PH_IDLE;
            seg_nxt   = 17'd0;
            res.done  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      seg_r         <= seg_nxt;
      elapsed_r     <= elapsed_nxt;
      shift_r       <= shift_nxt;
      saved_word_r  <= saved_word_nxt;
      bits_left_r   <= bits_left_nxt;
      saved_bits_r  <= saved_bits_nxt;
      frames_left_r <= frames_left_nxt;
    end
  end

`ifndef SYNTH
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && operation |=> phase_r == PH_PRE_MARK && seg_r == T_BIT_MARK)
    else $error("start beat did not load the leading mark");
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done |=> phase_r == PH_IDLE)
    else $error("sequencer still running after final tick");
  a_seg_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE && $past(step_en) |-> seg_r != 17'd0)
    else $error("segment timer empty while sending");
`endif

endmodule

// ===== rtl/core/ir_pulse_distance_frame_sender.sv =====
// Top level: input register, frame sequencer and result register.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid in_ready in_operation in_payload          | in
//          | in_bit_count in_repeat_count                       |
//  out     | out_valid out_ready out_ir_level out_busy_res      | out
//          | out_done_res                                       |
//
// One beat per cycle sustained while out_ready is high; a beat's result reaches
// the outputs through the input register, then the sequencer update into the
// result register.
// The sequencer state advances only when the result register can take a beat.
// Synchronous active-low reset empties both registers and idles the sequencer.
// A stalled output holds its beat; the input register still takes one more.
module ir_pulse_distance_frame_sender import irpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_payload,
  input  logic [6:0]  in_bit_count,
  input  logic [15:0] in_repeat_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ir_level,
  output logic        out_busy_res,
  output logic        out_done_res
);

  logic        in_v_r;
  logic        in_op_r;
  logic [63:0] in_payload_r;
  logic [6:0]  in_bits_r;
  logic [15:0] in_rep_r;
  logic        out_v_r;
  irpd_res_t   out_res_r;
  irpd_res_t   step_res;
  logic        step_en;

  assign step_en  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (step_en) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_op_r      <= in_operation;
      in_payload_r <= in_payload;
      in_bits_r    <= in_bit_count;
      in_rep_r     <= in_repeat_count;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  irpd_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .operation    (in_op_r),
    .payload      (in_payload_r),
    .bit_count    (in_bits_r),
    .repeat_count (in_rep_r),
    .res          (step_res)
  );

  assign out_valid    = out_v_r;
  assign out_ir_level = out_res_r.level;
  assign out_busy_res = out_res_r.busy;
  assign out_done_res = out_res_r.done;

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.done |-> out_res_r.busy)
    else $error("done beat without busy");
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && out_v_r && !out_ready |=> in_v_r)
    else $error("input beat dropped during output stall");
  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("stepped beat missing from result register");
`endif

endmodule

// ===== verif/irpd_frame_checker.sv =====
// Opcode package for the testbench and the checker that predicts and compares every result beat.
`timescale 1ns / 100ps

package irpd_tb_pkg;
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } irpd_op_t;
endpackage

module irpd_frame_checker
  import irpd_pkg::*;
  import irpd_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_payload,
  input  logic [6:0]  in_bit_count,
  input  logic [15:0] in_repeat_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_ir_level,
  input  logic        out_busy_res,
  input  logic        out_done_res,
  output int          fail_count,
  output int          pending,
  output int          beats_checked,
  output int          completions_seen
);

  localparam logic [16:0] US_SHORT     = 17'd750;
  localparam logic [16:0] US_ONE_SPACE = 17'd2150;
  localparam logic [16:0] US_HEADER    = 17'd2850;
  localparam logic [17:0] US_FRAME     = 18'd108000;
  localparam int          TYP_BITS     = 32;
  localparam logic [6:0]  BIT_LIMIT    = 7'd64;
  // shortest gap: frame length less a typical body, clamped at zero
  localparam int TYP_BODY   = 2 * (750 + 750) + TYP_BITS * (750 + 2150);
  localparam int US_MIN_GAP = (TYP_BODY < 108000) ? 108000 - TYP_BODY : 0;

  phase_t      tx_phase;
  logic [16:0] seg_left;
  logic [17:0] frame_us;
  logic [63:0] shift_reg;
  logic [63:0] word_hold;
  logic [6:0]  bits_rem;
  logic [6:0]  bits_hold;
  logic [15:0] frames_rem;

  irpd_res_t level_expect_q[$];
  irpd_res_t want;
  int fails = 0;
  int checked = 0;
  int completions = 0;

  function automatic void enter_segment(phase_t p, logic [16:0] dur);
    tx_phase = p;
    seg_left = dur;
    frame_us = frame_us + {1'b0, dur};
  endfunction

  function automatic void restart_frame();
    shift_reg = word_hold;
    bits_rem  = bits_hold;
    frame_us  = '0;
    enter_segment(PH_PRE_MARK, US_SHORT);
  endfunction

  // returns 1 when the whole transmission is over
  function automatic bit close_frame();
    if (frames_rem != 0) begin
      frames_rem = frames_rem - 16'd1;
      restart_frame();
      return 1'b0;
    end
    tx_phase = PH_IDLE;
    seg_left = '0;
    return 1'b1;
  endfunction

  function automatic bit segment_over();
    logic [17:0] gap;
    logic        one;
    case (tx_phase)
      PH_PRE_MARK:  enter_segment(PH_PRE_SPACE, US_SHORT);
      PH_PRE_SPACE: enter_segment(PH_HDR_MARK, US_HEADER);
      PH_HDR_MARK:  enter_segment(PH_HDR_SPACE, US_HEADER);
      PH_HDR_SPACE, PH_BIT_SPACE: enter_segment(PH_BIT_MARK, US_SHORT);
      PH_BIT_MARK: begin
        if (bits_rem != 0) begin
          one       = shift_reg[63];
          shift_reg = shift_reg << 1;
          bits_rem  = bits_rem - 7'd1;
          enter_segment(PH_BIT_SPACE, one ? US_ONE_SPACE : US_SHORT);
        end else begin
          // footer done: pad the frame out, saturating, never below the minimum gap
          gap = (frame_us < US_FRAME) ? US_FRAME - frame_us : '0;
          if (gap < 18'(US_MIN_GAP)) gap = 18'(US_MIN_GAP);
          if (gap == 0) return close_frame();
          tx_phase = PH_GAP;
          seg_left = gap[16:0];
        end
      end
      default: return close_frame();
    endcase
    return 1'b0;
  endfunction

  function automatic irpd_res_t predict_tick(logic op, logic [63:0] word, logic [6:0] nbits,
                                             logic [15:0] reps);
    irpd_res_t  r;
    logic [6:0] n;
    r = '0;
    if (op == OP_START) begin
      n          = (nbits > BIT_LIMIT) ? BIT_LIMIT : nbits;
      bits_hold  = n;
      word_hold  = (n != 0) ? word << (7'd64 - n) : '0;
      frames_rem = reps;
      restart_frame();
      r.busy = 1'b1;
    end else if (tx_phase != PH_IDLE) begin
      r.busy  = 1'b1;
      r.level = (tx_phase == PH_PRE_MARK) || (tx_phase == PH_HDR_MARK) ||
                (tx_phase == PH_BIT_MARK);
      if (seg_left != 0) seg_left = seg_left - 17'd1;
      if (seg_left == 0 && segment_over()) r.done = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string field, logic exp_b, logic got_b);
    if (got_b !== exp_b) begin
      $error("%s mismatch: expected %0b, got %0b", field, exp_b, got_b);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tx_phase   = PH_IDLE;
      seg_left   = '0;
      frame_us   = '0;
      shift_reg  = '0;
      word_hold  = '0;
      bits_rem   = '0;
      bits_hold  = '0;
      frames_rem = '0;
      level_expect_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (level_expect_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          fails++;
        end else begin
          want = level_expect_q.pop_front();
          check_field("ir_level", want.level, out_ir_level);
          check_field("busy_res", want.busy, out_busy_res);
          check_field("done_res", want.done, out_done_res);
          checked++;
          if (want.done) completions++;
        end
      end
      if (in_valid && in_ready)
        level_expect_q.push_back(predict_tick(in_operation, in_payload, in_bit_count,
                                              in_repeat_count));
    end
    fail_count       <= fails;
    pending          <= level_expect_q.size();
    beats_checked    <= checked;
    completions_seen <= completions;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, stimulus and idling for the IR frame sender, plus the verdict.
`timescale 1ns / 100ps

module tb_top import irpd_tb_pkg::*;;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_operation    = OP_TICK;
  logic [63:0] in_payload      = '0;
  logic [6:0]  in_bit_count    = '0;
  logic [15:0] in_repeat_count = '0;
  logic        out_ready       = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ir_level;
  logic        out_busy_res;
  logic        out_done_res;

  int fail_count;
  int pending;
  int beats_checked;
  int completions_seen;

  int send_idle_pct = 30;
  int recv_idle_pct = 46;
  bit hold_req      = 1'b0;
  bit hold_served   = 1'b0;
  int starts_sent   = 0;

  ir_pulse_distance_frame_sender dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_payload      (in_payload),
    .in_bit_count    (in_bit_count),
    .in_repeat_count (in_repeat_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ir_level    (out_ir_level),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res)
  );

  irpd_frame_checker frame_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_payload       (in_payload),
    .in_bit_count     (in_bit_count),
    .in_repeat_count  (in_repeat_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ir_level     (out_ir_level),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .fail_count       (fail_count),
    .pending          (pending),
    .beats_checked    (beats_checked),
    .completions_seen (completions_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(irpd_op_t op, logic [63:0] word, logic [6:0] nbits,
                           logic [15:0] reps);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_payload      <= word;
    in_bit_count    <= nbits;
    in_repeat_count <= reps;
    do @(posedge clk); while (!in_ready);
    if (op == OP_START) starts_sent++;
  endtask

  // tick beats carry random junk in the unused fields
  task automatic send_ticks(int n);
    repeat (n) send_beat(OP_TICK, {$urandom, $urandom}, 7'($urandom), 16'($urandom));
  endtask

  function automatic logic [6:0] pick_bit_count();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd64;
      2, 3:    return 7'($urandom_range(127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  // start plus a short run of ticks; sometimes a tick run with no fresh start
  task automatic random_transmissions(int count);
    int run;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(7) != 0)
        send_beat(OP_START, {$urandom, $urandom}, pick_bit_count(), 16'($urandom));
      run = $urandom_range(0, 60);
      send_ticks(run);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks, field extremes, restarts mid-transmission
    send_beat(OP_TICK, '1, '1, '1);
    send_beat(OP_TICK, '0, '0, '0);
    send_beat(OP_START, '1, 7'd127, 16'hFFFF);
    send_ticks(3);
    send_beat(OP_START, '0, 7'd65, 16'd0);
    send_ticks(2);
    // through the leading mark into the space after it
    send_beat(OP_START, 64'h8000_0000_0000_0000, 7'd64, 16'hFFFF);
    send_ticks(760);
    send_beat(OP_START, 64'hA5A5_0000_0000_0001, 7'd0, 16'd1);
    send_ticks(20);
    send_beat(OP_START, 64'h2, 7'd2, 16'd0);
    send_ticks(20);

    random_transmissions(6);

    send_idle_pct = 46;
    recv_idle_pct = 30;
    random_transmissions(6);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_transmissions(6);
    in_valid <= 1'b0;

    for (int w = 0; pending != 0 && w < 1000; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d expected result beats never arrived", pending);

    $display("Checked %0d result beats across %0d starts, %0d transmissions completed.",
             beats_checked, starts_sent, completions_seen);
    $display("Idling 30/46 then 46/30 then none, with one long receiver hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/irpd_pkg.sv
rtl/core/irpd_seq.sv
rtl/core/ir_pulse_distance_frame_sender.sv
verif/irpd_frame_checker.sv
verif/tb_top.sv
